FILE: rtl/bswp_pkg.sv
`timescale 1ns / 1ps

package bswp_pkg;

  localparam int DEPTH   = 256;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 9;
  localparam int GROUP   = 16;
  localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_TOP  = 2'd2,
    CMD_PEEK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BADPOS    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_REDUCE1 = 2'd1,
    S_REDUCE2 = 2'd2,
    S_DELIVER = 2'd3
  } state_t;

  // shift controls broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  localparam word_t FAIL_WORD = '1;

endpackage

FILE: rtl/bounded_stack_with_peek_unit.sv
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit words built as a row of 256 shift cells; cell 0
// always holds the top entry. Push, pop and read-top finish in the cycle the
// input beat is taken, so they run at one beat per cycle as long as the result
// beat is drained and no peek is in flight. A peek at position p selects cell
// p-1 and pulls it out through a two-level registered OR tree; the index, the
// group ORs, the tree result and the result beat are registered in turn. A
// peek at a bad position answers at once. capacity_limit (reset 256, values
// above 256 act as 256, zero means always full) is written through the cfg
// channel, which is always ready; write it only while no command is in flight.
module bounded_stack_with_peek_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  // command beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic signed [31:0] push_value,
  input  logic [8:0]  peek_position,
  // result beat
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] read_value,
  output logic [1:0]  status,
  output logic [8:0]  entry_count,
  output logic        is_empty,
  output logic        is_full
);
  import bswp_pkg::*;

  state_t     state, state_next;
  count_t     fill, fill_next;
  count_t     capacity_limit;
  count_t     cap_eff;
  logic [IDX_W-1:0] peek_idx;

  cell_ctl_t  ctl;
  word_t      cell_word   [DEPTH];
  word_t      cell_masked [DEPTH];
  logic [DEPTH-1:0] sel;
  word_t      tree_result;

  logic       accept;
  logic       push_ok, pop_ok, peek_ok;
  logic       start_peek;
  logic       load_now;
  logic       deliver;
  word_t      now_value;
  status_t    now_status;
  cmd_t       cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= count_t'(DEPTH);
    end else if (cfg_valid) begin
      capacity_limit <= cfg_data;
    end
  end

  // capacity in effect saturates at the row length
  assign cap_eff = (capacity_limit > count_t'(DEPTH)) ? count_t'(DEPTH) : capacity_limit;

  assign cmd     = cmd_t'(command);
  assign push_ok = fill < cap_eff;
  assign pop_ok  = fill != '0;
  assign peek_ok = (peek_position != '0) && (peek_position <= fill);

  // ---------------- control FSM ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept     = in_valid && in_ready;
  assign start_peek = accept && (cmd == CMD_PEEK) && peek_ok;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start_peek) state_next = S_REDUCE1;
      end
      S_REDUCE1: state_next = S_REDUCE2;
      S_REDUCE2: state_next = S_DELIVER;
      S_DELIVER: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    deliver  = 1'b0;
    case (state)
      S_IDLE:    in_ready = !out_valid || out_ready;
      S_DELIVER: deliver  = 1'b1;
      default: begin
        in_ready = 1'b0;
        deliver  = 1'b0;
      end
    endcase
  end

  // ---------------- immediate commands ----------------
  always_comb begin
    now_value  = FAIL_WORD;
    now_status = STAT_OK;
    fill_next  = fill;
    ctl        = '0;
    case (cmd)
      CMD_PUSH: begin
        if (push_ok) begin
          fill_next = fill + count_t'(1);
          ctl.push  = accept;
        end else begin
          now_status = STAT_OVERFLOW;
        end
      end
      CMD_POP: begin
        if (pop_ok) begin
          fill_next = fill - count_t'(1);
          ctl.pop   = accept;
          now_value = cell_word[0];
        end else begin
          now_status = STAT_UNDERFLOW;
        end
      end
      CMD_TOP: begin
        if (pop_ok) now_value = cell_word[0];
        else now_status = STAT_UNDERFLOW;
      end
      CMD_PEEK: begin
        if (!peek_ok) now_status = STAT_BADPOS;
      end
      default: now_status = STAT_OK;
    endcase
  end

  assign load_now = accept && !start_peek;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // position 1 is cell 0
  always_ff @(posedge clk) begin
    if (start_peek) begin
      peek_idx <= IDX_W'(peek_position - count_t'(1));
    end
  end

  // ---------------- cell row ----------------
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign sel[i] = peek_idx == IDX_W'(i);
      bswp_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .from_above ((i == 0) ? word_t'(push_value) : cell_word[(i == 0) ? 0 : i - 1]),
        .from_below (cell_word[(i == DEPTH - 1) ? i : i + 1]),
        .sel        (sel[i]),
        .word       (cell_word[i]),
        .masked     (cell_masked[i])
      );
    end
  endgenerate

  bswp_or_tree u_tree (
    .clk    (clk),
    .leaves (cell_masked),
    .result (tree_result)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_now || deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      read_value  <= now_value;
      status      <= now_status;
      entry_count <= fill_next;
      is_empty    <= fill_next == '0;
      is_full     <= fill_next >= cap_eff;
    end else if (deliver) begin
      read_value  <= tree_result;
      status      <= STAT_OK;
      entry_count <= fill;
      is_empty    <= fill == '0;
      is_full     <= fill >= cap_eff;
    end
  end

endmodule

FILE: rtl/bswp_cell.sv
`timescale 1ns / 1ps

module bswp_cell (
  input  logic              clk,
  input  bswp_pkg::cell_ctl_t ctl,
  input  bswp_pkg::word_t   from_above,
  input  bswp_pkg::word_t   from_below,
  input  logic              sel,
  output bswp_pkg::word_t   word,
  output bswp_pkg::word_t   masked
);
  import bswp_pkg::*;

  // push moves everything one cell deeper, pop one cell toward the top
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word <= from_above;
    end else if (ctl.pop) begin
      word <= from_below;
    end
  end

  assign masked = sel ? word : '0;

endmodule

FILE: rtl/bswp_or_tree.sv
`timescale 1ns / 1ps

module bswp_or_tree (
  input  logic                   clk,
  input  bswp_pkg::word_t        leaves [bswp_pkg::DEPTH],
  output bswp_pkg::word_t        result
);
  import bswp_pkg::*;

  word_t group_or  [NGROUP];
  word_t group_reg [NGROUP];
  word_t total_or;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          group_or[g] = group_or[g] | leaves[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      group_reg[g] <= group_or[g];
    end
  end

  always_comb begin
    total_or = '0;
    for (int g = 0; g < NGROUP; g++) begin
      total_or = total_or | group_reg[g];
    end
  end

  always_ff @(posedge clk) begin
    result <= total_or;
  end

endmodule
